// File: rtl/lir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the interval run block.
// Depends on nothing; every other file refers to it by scoped names.

package lir_pkg;

  localparam int LEN_FIELD_W = 11;
  localparam logic [LEN_FIELD_W-1:0] LEN_FIELD_MAX = 11'h7FF;

  // Control flags that travel with a request along the row of cells.
  typedef struct packed {
    logic valid;
    logic start;
    logic skip;
    logic last;
    logic chain_ok;
  } lir_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/lir_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for requests and results of the interval run block.
// Depends on lir_pkg for the result field width.

interface lir_in_if #(
  parameter int VALUE_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] a_value;
  logic signed [VALUE_BITS-1:0] b_value;
  logic                         last_item;

  modport source (output valid, a_value, b_value, last_item, input ready);
  modport sink   (input valid, a_value, b_value, last_item, output ready);
endinterface

interface lir_out_if ();
  logic                               valid;
  logic                               ready;
  logic [lir_pkg::LEN_FIELD_W-1:0]    best_length;
  logic                               sequence_done;
  logic                               length_overflow;

  modport source (output valid, best_length, sequence_done, length_overflow, input ready);
  modport sink   (input valid, best_length, sequence_done, length_overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/longest_intersecting_interval_run.sv
`timescale 1ns / 1ps
`default_nettype none
// Longest intersecting interval run: a row of MAX_LEN cells that each request passes.
// A request passes every cell's registers in order before its result enters the result queue.
// Throughput is one request per cycle while the two-entry result queue has room; a full queue stalls the row.
// Synchronous reset clears all control state; no clearing pass is needed.
// Depends on lir_pkg, lir_if, lir_cell and lir_out_stage.

module longest_intersecting_interval_run #(
  parameter int MAX_LEN    = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lir_in_if.sink    in_chan,
  lir_out_if.source out_chan
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);

  lir_pkg::lir_ctrl_t           ctrl_w [MAX_LEN+1];
  logic signed [VALUE_BITS-1:0] a_w    [MAX_LEN+1];
  logic signed [VALUE_BITS-1:0] b_w    [MAX_LEN+1];
  logic signed [VALUE_BITS-1:0] cmax_w [MAX_LEN+1];
  logic signed [VALUE_BITS-1:0] cmin_w [MAX_LEN+1];
  logic        [LEN_W-1:0]      len_w  [MAX_LEN+1];

  logic             adv;
  logic             accept;
  logic [LEN_W-1:0] pos_r;
  logic [LEN_W-1:0] pos_nxt;
  logic             at_limit;

  always_comb begin
    accept   = in_chan.valid && adv;
    at_limit = (pos_r == LEN_W'(MAX_LEN));
    if (in_chan.last_item) begin
      pos_nxt = '0;
    end else if (at_limit) begin
      pos_nxt = pos_r;
    end else begin
      pos_nxt = pos_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  assign in_chan.ready = adv;

  always_comb begin
    ctrl_w[0].valid    = accept;
    ctrl_w[0].start    = (pos_r == '0);
    ctrl_w[0].skip     = at_limit;
    ctrl_w[0].last     = in_chan.last_item;
    ctrl_w[0].chain_ok = 1'b1;
    a_w[0]             = in_chan.a_value;
    b_w[0]             = in_chan.b_value;
    cmax_w[0]          = {1'b1, {(VALUE_BITS-1){1'b0}}};
    cmin_w[0]          = {1'b0, {(VALUE_BITS-1){1'b1}}};
    len_w[0]           = '0;
  end

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    lir_cell #(
      .VALUE_BITS (VALUE_BITS),
      .LEN_W      (LEN_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctrl_i (ctrl_w[k]),
      .a_i    (a_w[k]),
      .b_i    (b_w[k]),
      .cmax_i (cmax_w[k]),
      .cmin_i (cmin_w[k]),
      .len_i  (len_w[k]),
      .ctrl_o (ctrl_w[k+1]),
      .a_o    (a_w[k+1]),
      .b_o    (b_w[k+1]),
      .cmax_o (cmax_w[k+1]),
      .cmin_o (cmin_w[k+1]),
      .len_o  (len_w[k+1])
    );
  end

  lir_out_stage #(
    .LEN_W (LEN_W)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl_i   (ctrl_w[MAX_LEN]),
    .len_i    (len_w[MAX_LEN]),
    .adv_o    (adv),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// File: rtl/lir_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One cell of the row: holds the largest a and smallest b over the newest k+1 positions.
// Depends on lir_pkg for the control flag struct.

module lir_cell #(
  parameter int VALUE_BITS = 32,
  parameter int LEN_W      = 11
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         adv,
  input  wire lir_pkg::lir_ctrl_t           ctrl_i,
  input  wire logic signed [VALUE_BITS-1:0] a_i,
  input  wire logic signed [VALUE_BITS-1:0] b_i,
  input  wire logic signed [VALUE_BITS-1:0] cmax_i,
  input  wire logic signed [VALUE_BITS-1:0] cmin_i,
  input  wire logic        [LEN_W-1:0]      len_i,
  output lir_pkg::lir_ctrl_t                ctrl_o,
  output logic signed [VALUE_BITS-1:0]      a_o,
  output logic signed [VALUE_BITS-1:0]      b_o,
  output logic signed [VALUE_BITS-1:0]      cmax_o,
  output logic signed [VALUE_BITS-1:0]      cmin_o,
  output logic        [LEN_W-1:0]           len_o
);

  logic signed [VALUE_BITS-1:0] max_r;
  logic signed [VALUE_BITS-1:0] min_r;
  logic                         ok_r;
  logic signed [VALUE_BITS-1:0] max_nxt;
  logic signed [VALUE_BITS-1:0] min_nxt;
  logic                         ok_nxt;
  logic                         upd;

  lir_pkg::lir_ctrl_t           ctrl_r;
  logic signed [VALUE_BITS-1:0] a_r;
  logic signed [VALUE_BITS-1:0] b_r;
  logic signed [VALUE_BITS-1:0] cmax_r;
  logic signed [VALUE_BITS-1:0] cmin_r;
  logic        [LEN_W-1:0]      len_r;

  always_comb begin
    max_nxt = (cmax_i > a_i) ? cmax_i : a_i;
    min_nxt = (cmin_i < b_i) ? cmin_i : b_i;
    ok_nxt  = ctrl_i.chain_ok && (max_nxt < min_nxt);
    upd     = adv && ctrl_i.valid && !ctrl_i.skip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else if (upd) begin
      ok_r <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      max_r <= max_nxt;
      min_r <= min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (adv) begin
      ctrl_r.valid    <= ctrl_i.valid;
      ctrl_r.start    <= ctrl_i.start;
      ctrl_r.skip     <= ctrl_i.skip;
      ctrl_r.last     <= ctrl_i.last;
      ctrl_r.chain_ok <= ok_r && !ctrl_i.start;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r    <= a_i;
      b_r    <= b_i;
      cmax_r <= max_r;
      cmin_r <= min_r;
      len_r  <= len_i + LEN_W'(ok_nxt);
    end
  end

  assign ctrl_o = ctrl_r;
  assign a_o    = a_r;
  assign b_o    = b_r;
  assign cmax_o = cmax_r;
  assign cmin_o = cmin_r;
  assign len_o  = len_r;

endmodule

`default_nettype wire

// File: rtl/lir_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// Best-length tracking and the two-entry result queue at the end of the row.
// Depends on lir_pkg and the result channel interface lir_out_if.

module lir_out_stage #(
  parameter int LEN_W = 11
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lir_pkg::lir_ctrl_t ctrl_i,
  input  wire logic [LEN_W-1:0]   len_i,
  output logic                    adv_o,
  lir_out_if.source               out_chan
);

  localparam int FW    = lir_pkg::LEN_FIELD_W;
  localparam int SAT_W = (LEN_W > FW) ? LEN_W : FW;

  logic [LEN_W-1:0] best_r;
  logic [LEN_W-1:0] best_nxt;
  logic [SAT_W-1:0] best_ext;
  logic [FW-1:0]    res_best;
  logic             pop;
  logic             res_v;

  logic             out_v_r;
  logic [FW-1:0]    out_best_r;
  logic             out_done_r;
  logic             out_ovf_r;
  logic             skid_v_r;
  logic [FW-1:0]    skid_best_r;
  logic             skid_done_r;
  logic             skid_ovf_r;

  always_comb begin
    if (ctrl_i.skip) begin
      best_nxt = best_r;
    end else begin
      best_nxt = (len_i > best_r) ? len_i : best_r;
    end
    best_ext = SAT_W'(best_nxt);
    res_best = (best_ext > SAT_W'(lir_pkg::LEN_FIELD_MAX)) ? lir_pkg::LEN_FIELD_MAX
                                                           : best_ext[FW-1:0];
    adv_o    = !skid_v_r;
    pop      = out_v_r && out_chan.ready;
    res_v    = adv_o && ctrl_i.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else if (res_v) begin
      best_r <= ctrl_i.last ? '0 : best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (res_v) begin
      if (out_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_best_r <= skid_best_r;
        out_done_r <= skid_done_r;
        out_ovf_r  <= skid_ovf_r;
      end
    end else if (res_v) begin
      if (out_v_r && !pop) begin
        skid_best_r <= res_best;
        skid_done_r <= ctrl_i.last;
        skid_ovf_r  <= ctrl_i.skip;
      end else begin
        out_best_r <= res_best;
        out_done_r <= ctrl_i.last;
        out_ovf_r  <= ctrl_i.skip;
      end
    end
  end

  assign out_chan.valid           = out_v_r;
  assign out_chan.best_length     = out_best_r;
  assign out_chan.sequence_done   = out_done_r;
  assign out_chan.length_overflow = out_ovf_r;

endmodule

`default_nettype wire
